@@ src/hhcrc_pkg.sv @@
// Shared package for the header hunt CRC frame receiver.
// Holds frame constants, the status code type, the result record and the CRC step.
// No dependencies.
package hhcrc_pkg;

    // Frame geometry
    localparam int FRAME_LEN = 16;
    localparam logic [5:0] LAST_IDX = 6'(FRAME_LEN - 1);
    localparam logic [5:0] CSUM_IDX = 6'(FRAME_LEN - 2);

    // Protocol constants
    localparam logic [7:0]  HDR_BYTE       = 8'h5A;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] TICK_MAX       = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

    // Item kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Result queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        STATUS_BUSY    = 2'd0,
        STATUS_GOOD    = 2'd1,
        STATUS_BAD     = 2'd2,
        STATUS_TIMEOUT = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last_of_frame;
        status_t    status;
    } result_t;

    // CRC-16/CCITT-FALSE update over one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/hhcrc_if.sv @@
// Channel interfaces for the frame receiver: input item and result item.
// Depends on nothing; payload widths follow the item fields.
interface hhcrc_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, func, rx_byte, input ready);
    modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface hhcrc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       last_of_frame;
    logic [1:0] status;

    modport source (output valid, data_byte, byte_index, last_of_frame, status, input ready);
    modport sink   (input valid, data_byte, byte_index, last_of_frame, status, output ready);
endinterface

@@ src/hhcrc_front.sv @@
// Front end: accepts bytes and ticks, hunts the header, runs the CRC and timeout.
// Pushes one result record per producing item into the queue.
// Depends on hhcrc_pkg and hhcrc_in_if.
module hhcrc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    hhcrc_in_if.sink             rx,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 queue_full,
    output logic                 push,
    output hhcrc_pkg::result_t   push_data
);

    logic [5:0]  byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  csum_lo_reg, csum_lo_next;
    logic [15:0] idle_reg, idle_next;
    logic [15:0] timeout_reg;
    logic [15:0] idle_inc;
    logic        accept;

    assign rx.ready = !queue_full;
    assign accept   = rx.valid && rx.ready;
    assign idle_inc = (idle_reg == hhcrc_pkg::TICK_MAX) ? idle_reg : idle_reg + 16'd1;

    // Classify the item and work out the next state and result
    always_comb
    begin
        byte_count_next          = byte_count_reg;
        crc_next                 = crc_reg;
        csum_lo_next             = csum_lo_reg;
        idle_next                = idle_reg;
        push                     = 1'b0;
        push_data.data_byte      = 8'h00;
        push_data.byte_index     = 6'd0;
        push_data.last_of_frame  = 1'b0;
        push_data.status         = hhcrc_pkg::STATUS_BUSY;
        if (accept)
        begin
            // Bytes that are not the header while hunting fall through and are dropped
            if (rx.func == hhcrc_pkg::FUNC_TICK)
            begin
                idle_next = idle_inc;
                if (idle_inc >= timeout_reg)
                begin
                    byte_count_next         = 6'd0;
                    crc_next                = hhcrc_pkg::CRC_INIT;
                    csum_lo_next            = 8'h00;
                    idle_next               = 16'd0;
                    push                    = 1'b1;
                    push_data.last_of_frame = 1'b1;
                    push_data.status        = hhcrc_pkg::STATUS_TIMEOUT;
                end
            end
            else if (byte_count_reg != 6'd0 || rx.rx_byte == hhcrc_pkg::HDR_BYTE)
            begin
                push                 = 1'b1;
                push_data.data_byte  = rx.rx_byte;
                push_data.byte_index = byte_count_reg;
                if (byte_count_reg >= hhcrc_pkg::LAST_IDX)
                begin
                    // Final byte: compare the little-endian checksum and restart
                    push_data.last_of_frame = 1'b1;
                    if ({rx.rx_byte, csum_lo_reg} == crc_reg)
                    begin
                        push_data.status = hhcrc_pkg::STATUS_GOOD;
                        idle_next        = 16'd0;
                    end
                    else
                    begin
                        push_data.status = hhcrc_pkg::STATUS_BAD;
                    end
                    byte_count_next = 6'd0;
                    crc_next        = hhcrc_pkg::CRC_INIT;
                    csum_lo_next    = 8'h00;
                end
                else
                begin
                    if (byte_count_reg == hhcrc_pkg::CSUM_IDX)
                    begin
                        csum_lo_next = rx.rx_byte;
                    end
                    else
                    begin
                        crc_next = hhcrc_pkg::crc_byte(crc_reg, rx.rx_byte);
                    end
                    byte_count_next = byte_count_reg + 6'd1;
                end
            end
        end
    end

    // Hold frame state and the timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 6'd0;
            crc_reg        <= hhcrc_pkg::CRC_INIT;
            csum_lo_reg    <= 8'h00;
            idle_reg       <= 16'd0;
            timeout_reg    <= hhcrc_pkg::TIMEOUT_RESET;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            csum_lo_reg    <= csum_lo_next;
            idle_reg       <= idle_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // Frame position never passes the final byte
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= hhcrc_pkg::LAST_IDX)
        else $error("byte count beyond frame end");

    // A timeout clears the partial frame and the tick count
    a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.status == hhcrc_pkg::STATUS_TIMEOUT)
        |=> (byte_count_reg == 6'd0 && idle_reg == 16'd0 && crc_reg == hhcrc_pkg::CRC_INIT))
        else $error("timeout did not clear frame state");

    // Nothing is pushed into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("push into full queue");

endmodule

@@ src/hhcrc_queue.sv @@
// Short result queue that decouples the front end from the output stage.
// Register array with read and write pointers and a fill count.
// Depends on hhcrc_pkg.
module hhcrc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hhcrc_pkg::result_t   push_data,
    input  logic                 pop,
    output hhcrc_pkg::result_t   head,
    output logic                 empty,
    output logic                 full
);

    localparam logic [hhcrc_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        hhcrc_pkg::QUEUE_PTR_W'(hhcrc_pkg::QUEUE_DEPTH - 1);
    localparam logic [hhcrc_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        hhcrc_pkg::QUEUE_CNT_W'(hhcrc_pkg::QUEUE_DEPTH);

    hhcrc_pkg::result_t mem_reg [hhcrc_pkg::QUEUE_DEPTH];
    logic [hhcrc_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hhcrc_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [hhcrc_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_FULL);
    assign head  = mem_reg[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the entry; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

@@ src/hhcrc_back.sv @@
// Output stage: takes records from the queue into an output register.
// Drives the result channel and frees the queue on each take.
// Depends on hhcrc_pkg and hhcrc_out_if.
module hhcrc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hhcrc_pkg::result_t   head,
    input  logic                 queue_empty,
    output logic                 pop,
    hhcrc_out_if.source          res
);

    logic               out_valid_reg, out_valid_next;
    hhcrc_pkg::result_t out_data_reg;

    // Load when the register is free or being taken this cycle
    assign pop = !queue_empty && (!out_valid_reg || res.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= head;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.data_byte     = out_data_reg.data_byte;
    assign res.byte_index    = out_data_reg.byte_index;
    assign res.last_of_frame = out_data_reg.last_of_frame;
    assign res.status        = out_data_reg.status;

endmodule

@@ src/header_hunt_crc_frame_receiver.sv @@
// Header hunting frame receiver with CRC-16/CCITT-FALSE check and tick timeout.
// Each result passes through a queue entry, then the output register, before it shows as valid on the result channel.
// Throughput: one item per cycle while the queue is not full; the per-byte CRC update is a combinational XOR network.
// A four-entry queue lets input continue while results wait to be taken.
// Reset (async, active low): hunting, CRC 0xFFFF, tick count 0, timeout 1000, queue empty.
module header_hunt_crc_frame_receiver (
    input  logic         clk,
    input  logic         rst_n,
    hhcrc_in_if.sink     rx,
    hhcrc_out_if.source  res,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data
);

    hhcrc_pkg::result_t push_data;
    hhcrc_pkg::result_t head;
    logic               push;
    logic               pop;
    logic               queue_full;
    logic               queue_empty;

    // Classify items and track frame state
    hhcrc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .queue_full  (queue_full),
        .push        (push),
        .push_data   (push_data)
    );

    // Hold results between the two sides
    hhcrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    // Deliver results
    hhcrc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .res         (res)
    );

endmodule
